/* hw/rtl/gta_pkg.sv */
package gta_pkg;

   localparam int MAX_CLUSTERS_DEF = 16;
   localparam int COORD_BITS_DEF   = 16;
   localparam logic [15:0] MAX_MOVEMENT_RESET = 16'd1000;

   localparam logic CMD_ADD   = 1'b0;
   localparam logic CMD_CLOSE = 1'b1;

   typedef struct packed {
      logic               cmd;
      logic signed [15:0] coord_x;
      logic signed [15:0] coord_y;
      logic signed [15:0] coord_z;
   } req_word_type;

   typedef struct packed {
      logic [3:0]  cluster_index;
      logic [15:0] track_id;
      logic        matched;
      logic [3:0]  prev_index;
      logic        overflow;
      logic        last;
   } rsp_word_type;

endpackage

/* hw/rtl/greedy_track_association.sv */
// Channel   Direction  Word                     Handshake
// req_      in         gta_pkg::req_word_type   req_valid / req_ready
// rsp_      out        gta_pkg::rsp_word_type   rsp_valid / rsp_ready
// csr_      in         max_movement, 16 bits    csr_valid / csr_ready
//
// An add word is taken while the block is idle. A close word runs greedy
// passes over the unused (previous, current) pairs, with up to
// min(previous, current) + 1 passes, using the single shared multiplier
// that squares one axis difference per cycle; then it hands out new ids
// cluster by cluster and sends one result per cluster, each held until rsp_ready.
// Reset is synchronous and active high; it clears only the control state and sets max_movement to its reset value.
// The block takes no request word while a close is in progress.
module greedy_track_association #(
   parameter int MAX_CLUSTERS = gta_pkg::MAX_CLUSTERS_DEF,
   parameter int COORD_BITS   = gta_pkg::COORD_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  gta_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output gta_pkg::rsp_word_type rsp_word,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [15:0]           csr_data
);

   // Index width, count width, multiplier operand width, product width and distance width.
   localparam int IW = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
   localparam int CW = $clog2(MAX_CLUSTERS + 1);
   localparam int MW = (COORD_BITS + 1 > 17) ? COORD_BITS + 1 : 17;
   localparam int PW = 2 * MW;
   localparam int DW = PW + 2;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_THR   = 4'd1;
   localparam logic [3:0] S_THR2  = 4'd2;
   localparam logic [3:0] S_PINIT = 4'd3;
   localparam logic [3:0] S_ADDR  = 4'd4;
   localparam logic [3:0] S_SQ    = 4'd5;
   localparam logic [3:0] S_CMP   = 4'd6;
   localparam logic [3:0] S_PEND  = 4'd7;
   localparam logic [3:0] S_NEW   = 4'd8;
   localparam logic [3:0] S_ERD   = 4'd9;
   localparam logic [3:0] S_EOUT  = 4'd10;
   localparam logic [3:0] S_EWAIT = 4'd11;
   localparam logic [3:0] S_FIN   = 4'd12;

   // Centroid and id memories.
   logic signed [COORD_BITS-1:0] prev_x_mem [MAX_CLUSTERS];
   logic signed [COORD_BITS-1:0] prev_y_mem [MAX_CLUSTERS];
   logic signed [COORD_BITS-1:0] prev_z_mem [MAX_CLUSTERS];
   logic [15:0]                  prev_id_mem [MAX_CLUSTERS];
   logic signed [COORD_BITS-1:0] cur_x_mem [MAX_CLUSTERS];
   logic signed [COORD_BITS-1:0] cur_y_mem [MAX_CLUSTERS];
   logic signed [COORD_BITS-1:0] cur_z_mem [MAX_CLUSTERS];
   logic [15:0]                  asg_id_mem [MAX_CLUSTERS];
   logic [IW-1:0]                mrow_mem [MAX_CLUSTERS];

   logic signed [COORD_BITS-1:0] px_rd_ff, py_rd_ff, pz_rd_ff;
   logic signed [COORD_BITS-1:0] cx_rd_ff, cy_rd_ff, cz_rd_ff;
   logic [15:0]                  pid_rd_ff, aid_rd_ff;
   logic [IW-1:0]                mrow_rd_ff;

   logic [3:0]  state_ff, state_in;
   logic [15:0] max_mov_ff, max_mov_in;
   logic [CW-1:0] prev_count_ff, prev_count_in;
   logic [CW-1:0] cur_count_ff, cur_count_in;
   logic          overflow_ff, overflow_in;
   logic [MAX_CLUSTERS-1:0] row_used_ff, row_used_in;
   logic [MAX_CLUSTERS-1:0] col_used_ff, col_used_in;
   logic [MAX_CLUSTERS-1:0] is_matched_ff, is_matched_in;
   logic [CW-1:0] r_ff, r_in, c_ff, c_in;
   logic [1:0]    k_ff, k_in;
   logic [PW-1:0] prod_ff, prod_in;
   logic [DW-1:0] acc_ff, acc_in, best_ff, best_in, thr_ff, thr_in;
   logic          found_ff, found_in;
   logic [IW-1:0] br_ff, br_in, bc_ff, bc_in;
   logic [15:0]   bid_ff, bid_in;
   logic [15:0]   largest_ff, largest_in;
   logic [15:0]   prev_max_ff, prev_max_in;
   logic [15:0]   new_max_ff, new_max_in;
   logic          rsp_valid_ff, rsp_valid_in;
   gta_pkg::rsp_word_type rsp_word_ff, rsp_word_in;

   logic [IW-1:0] r_idx, c_idx;
   logic signed [MW-1:0] mul_a;
   logic signed [PW-1:0] mul_p;
   logic          req_take;
   logic          add_write, match_write, new_write, copy_write;

   // Coordinates keep their low COORD_BITS bits; a wider setting sees the
   // port value as a zero-extended number.
   function automatic logic signed [COORD_BITS-1:0] to_coord(input logic [15:0] v);
      logic [COORD_BITS+15:0] t;
      t = {{COORD_BITS{1'b0}}, v};
      return t[COORD_BITS-1:0];
   endfunction

   function automatic logic [3:0] to_nib(input logic [IW-1:0] v);
      logic [IW+3:0] t;
      t = {4'b0000, v};
      return t[3:0];
   endfunction

   assign r_idx     = r_ff[IW-1:0];
   assign c_idx     = c_ff[IW-1:0];
   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;
   assign req_take  = req_valid && req_ready;

   // The one shared multiplier squares the threshold or one axis difference.
   always_comb begin
      mul_a = '0;
      if (state_ff == S_THR) begin
         mul_a = MW'(signed'({1'b0, max_mov_ff}));
      end else begin
         case (k_ff)
            2'd0:    mul_a = MW'(px_rd_ff) - MW'(cx_rd_ff);
            2'd1:    mul_a = MW'(py_rd_ff) - MW'(cy_rd_ff);
            2'd2:    mul_a = MW'(pz_rd_ff) - MW'(cz_rd_ff);
            default: mul_a = '0;
         endcase
      end
      mul_p = mul_a * mul_a;
   end

   always_comb begin
      state_in      = state_ff;
      max_mov_in    = max_mov_ff;
      prev_count_in = prev_count_ff;
      cur_count_in  = cur_count_ff;
      overflow_in   = overflow_ff;
      row_used_in   = row_used_ff;
      col_used_in   = col_used_ff;
      is_matched_in = is_matched_ff;
      r_in          = r_ff;
      c_in          = c_ff;
      k_in          = k_ff;
      prod_in       = prod_ff;
      acc_in        = acc_ff;
      best_in       = best_ff;
      thr_in        = thr_ff;
      found_in      = found_ff;
      br_in         = br_ff;
      bc_in         = bc_ff;
      bid_in        = bid_ff;
      largest_in    = largest_ff;
      prev_max_in   = prev_max_ff;
      new_max_in    = new_max_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_word_in   = rsp_word_ff;
      add_write     = 1'b0;
      match_write   = 1'b0;
      new_write     = 1'b0;
      copy_write    = 1'b0;

      if (csr_valid && csr_ready) begin
         max_mov_in = csr_data;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               if (req_word.cmd == gta_pkg::CMD_ADD) begin
                  if (cur_count_ff < CW'(MAX_CLUSTERS)) begin
                     add_write    = 1'b1;
                     cur_count_in = cur_count_ff + CW'(1);
                  end else begin
                     overflow_in = 1'b1;
                  end
               end else begin
                  state_in = S_THR;
               end
            end
         end
         S_THR: begin
            prod_in       = PW'(mul_p);
            row_used_in   = '0;
            col_used_in   = '0;
            is_matched_in = '0;
            state_in      = S_THR2;
         end
         S_THR2: begin
            thr_in   = DW'(prod_ff);
            state_in = S_PINIT;
         end
         S_PINIT: begin
            found_in = 1'b0;
            r_in     = '0;
            c_in     = '0;
            state_in = S_ADDR;
         end
         S_ADDR: begin
            // Walk the pairs in row-major order, skipping used rows and columns.
            if (r_ff >= prev_count_ff) begin
               state_in = S_PEND;
            end else if (row_used_ff[r_idx] || c_ff >= cur_count_ff) begin
               r_in = r_ff + CW'(1);
               c_in = '0;
            end else if (col_used_ff[c_idx]) begin
               c_in = c_ff + CW'(1);
            end else begin
               k_in     = 2'd0;
               state_in = S_SQ;
            end
         end
         S_SQ: begin
            prod_in = PW'(mul_p);
            acc_in  = (k_ff == 2'd0) ? '0 : acc_ff + DW'(prod_ff);
            k_in    = k_ff + 2'd1;
            if (k_ff == 2'd3) begin
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            if (!found_ff || acc_ff < best_ff) begin
               found_in = 1'b1;
               best_in  = acc_ff;
               br_in    = r_idx;
               bc_in    = c_idx;
               bid_in   = pid_rd_ff;
            end
            c_in     = c_ff + CW'(1);
            state_in = S_ADDR;
         end
         S_PEND: begin
            if (found_ff && best_ff < thr_ff) begin
               match_write          = 1'b1;
               is_matched_in[bc_ff] = 1'b1;
               row_used_in[br_ff]   = 1'b1;
               col_used_in[bc_ff]   = 1'b1;
               state_in             = S_PINIT;
            end else begin
               c_in       = '0;
               largest_in = prev_max_ff;
               state_in   = S_NEW;
            end
         end
         S_NEW: begin
            if (c_ff >= cur_count_ff) begin
               c_in       = '0;
               new_max_in = '0;
               state_in   = (cur_count_ff == '0) ? S_FIN : S_ERD;
            end else begin
               if (!is_matched_ff[c_idx]) begin
                  new_write  = 1'b1;
                  largest_in = largest_ff + 16'd1;
               end
               c_in = c_ff + CW'(1);
            end
         end
         S_ERD: begin
            state_in = S_EOUT;
         end
         S_EOUT: begin
            copy_write                = 1'b1;
            rsp_valid_in              = 1'b1;
            rsp_word_in.cluster_index = to_nib(c_idx);
            rsp_word_in.track_id      = aid_rd_ff;
            rsp_word_in.matched       = is_matched_ff[c_idx];
            rsp_word_in.prev_index    = is_matched_ff[c_idx] ? to_nib(mrow_rd_ff) : 4'd0;
            rsp_word_in.overflow      = overflow_ff;
            rsp_word_in.last          = (c_ff + CW'(1) == cur_count_ff);
            if (aid_rd_ff > new_max_ff) begin
               new_max_in = aid_rd_ff;
            end
            c_in     = c_ff + CW'(1);
            state_in = S_EWAIT;
         end
         S_EWAIT: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               state_in     = (c_ff == cur_count_ff) ? S_FIN : S_ERD;
            end
         end
         S_FIN: begin
            prev_count_in = cur_count_ff;
            prev_max_in   = new_max_ff;
            cur_count_in  = '0;
            overflow_in   = 1'b0;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      px_rd_ff   <= prev_x_mem[r_idx];
      py_rd_ff   <= prev_y_mem[r_idx];
      pz_rd_ff   <= prev_z_mem[r_idx];
      pid_rd_ff  <= prev_id_mem[r_idx];
      cx_rd_ff   <= cur_x_mem[c_idx];
      cy_rd_ff   <= cur_y_mem[c_idx];
      cz_rd_ff   <= cur_z_mem[c_idx];
      aid_rd_ff  <= asg_id_mem[c_idx];
      mrow_rd_ff <= mrow_mem[c_idx];
      if (add_write) begin
         cur_x_mem[cur_count_ff[IW-1:0]] <= to_coord(req_word.coord_x);
         cur_y_mem[cur_count_ff[IW-1:0]] <= to_coord(req_word.coord_y);
         cur_z_mem[cur_count_ff[IW-1:0]] <= to_coord(req_word.coord_z);
      end
      if (match_write) begin
         asg_id_mem[bc_ff] <= bid_ff;
         mrow_mem[bc_ff]   <= br_ff;
      end else if (new_write) begin
         asg_id_mem[c_idx] <= largest_ff + 16'd1;
      end
      // The result being sent is copied into the previous frame.
      if (copy_write) begin
         prev_x_mem[c_idx]  <= cx_rd_ff;
         prev_y_mem[c_idx]  <= cy_rd_ff;
         prev_z_mem[c_idx]  <= cz_rd_ff;
         prev_id_mem[c_idx] <= aid_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         max_mov_ff    <= gta_pkg::MAX_MOVEMENT_RESET;
         prev_count_ff <= '0;
         cur_count_ff  <= '0;
         overflow_ff   <= 1'b0;
         row_used_ff   <= '0;
         col_used_ff   <= '0;
         is_matched_ff <= '0;
         found_ff      <= 1'b0;
         prev_max_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         max_mov_ff    <= max_mov_in;
         prev_count_ff <= prev_count_in;
         cur_count_ff  <= cur_count_in;
         overflow_ff   <= overflow_in;
         row_used_ff   <= row_used_in;
         col_used_ff   <= col_used_in;
         is_matched_ff <= is_matched_in;
         found_ff      <= found_in;
         prev_max_ff   <= prev_max_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      r_ff        <= r_in;
      c_ff        <= c_in;
      k_ff        <= k_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      best_ff     <= best_in;
      thr_ff      <= thr_in;
      br_ff       <= br_in;
      bc_ff       <= bc_in;
      bid_ff      <= bid_in;
      largest_ff  <= largest_in;
      new_max_ff  <= new_max_in;
      rsp_word_ff <= rsp_word_in;
   end

endmodule

/* hw/rtl/gta_checker.sv */
module gta_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input gta_pkg::req_word_type req_word,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input gta_pkg::rsp_word_type rsp_word
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("result word changed while stalled");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken while a result is pending");

   a_add_quiet: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_word.cmd == gta_pkg::CMD_ADD |=> !rsp_valid)
      else $error("add word produced a result");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_word.last |-> ##2 req_ready)
      else $error("block not ready after the final result");

   a_mid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_word.last |=> !req_ready)
      else $error("block ready in the middle of a frame");

endmodule

bind greedy_track_association gta_checker u_gta_checker (.*);
